/* rtl/sitrt_pkg.sv */
// Shared types, constants and the symbol table lookup for the radix text converter.
// No dependencies.
package sitrt_pkg;

  localparam int RADIX_W     = 5;
  localparam int SYM_W       = 8;
  localparam int NUM_SYMBOLS = 16;
  localparam int SYM_IDX_W   = 4;
  localparam int SYM_TAB_W   = NUM_SYMBOLS * SYM_W;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SYM_W-1:0]   SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0]   SYM_MINUS = 8'h2D;
  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  localparam logic [RADIX_W-1:0]    RADIX_RESET    = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYM_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] SYM_HIGH_RESET = 64'h0000_0000_0000_3131;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_SYM_LOW  = 2'd1,
    REG_SYM_HIGH = 2'd2
  } cfg_reg_t;

  // Table check result, done pulses for one cycle.
  typedef struct packed {
    logic done;
    logic ok;
  } chk_status_t;

  function automatic logic [SYM_W-1:0] symbol_of(input logic [SYM_TAB_W-1:0] tab,
                                                 input logic [SYM_IDX_W-1:0] d);
    return tab[d * SYM_W +: SYM_W];
  endfunction

endpackage

/* rtl/sitrt_check.sv */
// Symbol table checker: range-checks the radix, walks the in-use symbols one per
// cycle, looking for sign characters and duplicates. Depends on sitrt_pkg.
module sitrt_check import sitrt_pkg::*; #(
  parameter int MAX_RADIX = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RADIX_W-1:0]   radix,
  input  logic [SYM_TAB_W-1:0] symbols,
  output chk_status_t          status
);

  logic                 running;
  logic [SYM_IDX_W-1:0] idx;
  logic [SYM_W-1:0]     cur;
  logic                 hit;
  logic                 range_bad;
  logic                 at_end;

  always_comb begin
    cur = symbol_of(symbols, idx);
    hit = (cur == SYM_PLUS) || (cur == SYM_MINUS);
    // compare against every later in-use symbol at once
    for (int j = 0; j < NUM_SYMBOLS; j++) begin
      if ((RADIX_W'(j) < radix) && (SYM_IDX_W'(j) > idx) &&
          (symbol_of(symbols, SYM_IDX_W'(j)) == cur)) begin
        hit = 1'b1;
      end
    end
    range_bad = (radix < MIN_RADIX) || (radix > RADIX_W'(MAX_RADIX));
    at_end    = ({1'b0, idx} + 1'b1) == radix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      status  <= '0;
      idx     <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        if (range_bad) begin
          status <= '{done: 1'b1, ok: 1'b0};
        end else begin
          running <= 1'b1;
          idx     <= '0;
        end
      end else if (running) begin
        if (hit) begin
          running <= 1'b0;
          status  <= '{done: 1'b1, ok: 1'b0};
        end else if (at_end) begin
          running <= 1'b0;
          status  <= '{done: 1'b1, ok: 1'b1};
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  a_done_not_running: assert property (@(posedge clk) disable iff (rst)
    status.done |-> !running)
    else $error("check done while still walking the table");
  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    (status.done && status.ok) |-> !range_bad)
    else $error("table passed with radix out of range");
  a_idx_in_use: assert property (@(posedge clk) disable iff (rst)
    running |-> ({1'b0, idx} < radix))
    else $error("check index beyond radix");

endmodule

/* rtl/signed_integer_to_radix_text.sv */
// Top level: signed integer to text in a configurable radix, one character per item.
// Depends on sitrt_pkg and sitrt_check.
//
// Usage:
//   Input channel (value, in_valid, in_stall): one signed integer per item. in_stall is
//   high whenever a conversion is under way; one value is converted at a time.
//   Output channel (symbol, last, out_valid, out_stall): one character per item, a
//   leading '-' for negative values, then digits most significant first; last marks
//   the final digit. A single output register parts the two sides, so the next value
//   can be taken while the final character still waits.
//   Configuration (cfg_write, cfg_index, cfg_data): 0 radix, 1 symbols 0..7,
//   2 symbols 8..15. Write only while idle.
// Steps per value: accept, table check, then a bit-serial long division by the radix
//   for each digit, then the characters, each held while the receiver stalls.
// An unusable table (radix out of range, sign or repeated symbol) gives no output.
// Reset restores radix 10 and the default symbols and empties the output register.
// A stall on the output holds the current character; it does not hold the divider.
module signed_integer_to_radix_text import sitrt_pkg::*; #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [SYM_W-1:0]            symbol,
  output logic                        last
);

  localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int BIT_W   = $clog2(VALUE_BITS);
  localparam int ND_W    = $clog2(VALUE_BITS + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_SIGN   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                  state;
  logic [RADIX_W-1:0]      radix;
  logic [CFG_DATA_W-1:0]   symbols_low;
  logic [CFG_DATA_W-1:0]   symbols_high;
  logic [SYM_TAB_W-1:0]    symbols;

  logic                    neg;
  logic [VALUE_BITS-1:0]   quo;
  logic [DIGIT_W-1:0]      rem;
  logic [BIT_W-1:0]        bitcnt;
  logic [ND_W-1:0]         nd;
  logic [DIGIT_W-1:0]      stack [VALUE_BITS];

  logic                    accept;
  logic                    slot_free;
  logic                    chk_start;
  chk_status_t             chk;
  logic [DIGIT_W:0]        trial;
  logic                    qbit;
  logic [DIGIT_W-1:0]      rem_next;
  logic [VALUE_BITS-1:0]   quo_next;
  logic [ND_W-1:0]         nd_inc;
  logic                    pass_end;

  assign symbols   = {symbols_high, symbols_low};
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign chk_start = accept;
  assign slot_free = !out_valid || !out_stall;

  // One restoring division step: remainder doubles and takes the next dividend bit.
  always_comb begin
    trial    = {rem, quo[VALUE_BITS-1]};
    qbit     = RADIX_W'(trial) >= radix;
    rem_next = qbit ? DIGIT_W'(RADIX_W'(trial) - radix) : DIGIT_W'(trial);
    quo_next = {quo[VALUE_BITS-2:0], qbit};
    nd_inc   = nd + 1'b1;
    pass_end = (bitcnt == BIT_W'(VALUE_BITS - 1));
  end

  sitrt_check #(
    .MAX_RADIX(MAX_RADIX)
  ) u_check (
    .clk    (clk),
    .rst    (rst),
    .start  (chk_start),
    .radix  (radix),
    .symbols(symbols),
    .status (chk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= RADIX_RESET;
      symbols_low  <= SYM_LOW_RESET;
      symbols_high <= SYM_HIGH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIX:    radix        <= cfg_data[RADIX_W-1:0];
        REG_SYM_LOW:  symbols_low  <= cfg_data;
        REG_SYM_HIGH: symbols_high <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      nd        <= '0;
      bitcnt    <= '0;
    end else begin
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            neg   <= value[VALUE_BITS-1];
            quo   <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (chk.done) begin
            rem    <= '0;
            bitcnt <= '0;
            nd     <= '0;
            state  <= chk.ok ? ST_DIVIDE : ST_IDLE;
          end
        end
        ST_DIVIDE: begin
          quo <= quo_next;
          if (pass_end) begin
            nd     <= nd_inc;
            rem    <= '0;
            bitcnt <= '0;
            if (quo_next == '0 || nd_inc >= ND_W'(VALUE_BITS)) begin
              state <= neg ? ST_SIGN : ST_EMIT;
            end
          end else begin
            rem    <= rem_next;
            bitcnt <= bitcnt + 1'b1;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            symbol    <= SYM_MINUS;
            last      <= 1'b0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            symbol    <= symbol_of(symbols, SYM_IDX_W'(stack[0]));
            last      <= (nd == ND_W'(1));
            nd        <= nd - 1'b1;
            if (nd == ND_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Digit stack: push at the end of each division pass, pop on each digit sent.
  // Least significant digit goes in first, so the top holds the leading digit.
  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && pass_end) begin
      stack[0] <= rem_next;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (state == ST_EMIT && slot_free) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register not one-hot");
  a_nd_bound: assert property (@(posedge clk) disable iff (rst)
    nd <= ND_W'(VALUE_BITS))
    else $error("digit stack overflow");
  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT || state == ST_SIGN) |-> nd != '0)
    else $error("emitting with an empty digit stack");
  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE |-> RADIX_W'(rem) < radix)
    else $error("remainder not below radix");
  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && slot_free && nd == ND_W'(1)) |=> (state == ST_IDLE && last))
    else $error("final digit sent without returning to idle");

endmodule

/* sim/signed_integer_to_radix_text_test.sv */
// Testbench for signed_integer_to_radix_text: a scoreboard class predicts the text of
// each accepted value and checks every character; plain tasks drive the input channel
// and the configuration. Depends on sitrt_pkg and the block's RTL.
module signed_integer_to_radix_text_test;
  import sitrt_pkg::*;

  localparam int MAX_RADIX    = 16;
  localparam int VALUE_BITS   = 32;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 430;

  localparam logic [CFG_DATA_W-1:0] HEX_LOW       = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] HEX_HIGH      = 64'h4645_4443_4241_3938;
  localparam logic [CFG_DATA_W-1:0] DEC_LOW_INIT  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] DEC_HIGH_INIT = 64'h0000_0000_0000_3131;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } text_char_t;

  class radix_text_scoreboard;
    logic [RADIX_W-1:0]    radix;
    logic [CFG_DATA_W-1:0] sym_lo;
    logic [CFG_DATA_W-1:0] sym_hi;
    text_char_t            pending_chars[$];
    int                    mismatches;

    function new();
      radix      = RADIX_RESET;
      sym_lo     = DEC_LOW_INIT;
      sym_hi     = DEC_HIGH_INIT;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_RADIX:    radix  = d[RADIX_W-1:0];
        REG_SYM_LOW:  sym_lo = d;
        REG_SYM_HIGH: sym_hi = d;
        default: ;
      endcase
    endfunction

    function logic [SYM_W-1:0] symbol_at(int d);
      logic [2*CFG_DATA_W-1:0] tab;
      tab = {sym_hi, sym_lo};
      return tab[d*SYM_W +: SYM_W];
    endfunction

    function bit table_ok();
      int               n;
      logic [SYM_W-1:0] s;
      n = radix;
      if (n < MIN_RADIX || n > MAX_RADIX) return 0;
      for (int i = 0; i < n; i++) begin
        s = symbol_at(i);
        if (s == SYM_PLUS || s == SYM_MINUS) return 0;
        for (int j = i + 1; j < n; j++)
          if (s == symbol_at(j)) return 0;
      end
      return 1;
    endfunction

    // Queue the characters of one accepted value, sign first, MSD first.
    function void note_value(logic signed [VALUE_BITS-1:0] v);
      logic [VALUE_BITS-1:0] mag;
      logic [3:0]            digs[$];
      text_char_t            c;
      if (!table_ok()) return;
      mag = v;
      if (v[VALUE_BITS-1]) mag = ~mag + 1'b1;
      do begin
        digs.push_front(4'(mag % {27'd0, radix}));
        mag = mag / {27'd0, radix};
      end while (mag != 0);
      if (v[VALUE_BITS-1]) begin
        c.symbol = SYM_MINUS;
        c.last   = 1'b0;
        pending_chars.push_back(c);
      end
      foreach (digs[k]) begin
        c.symbol = symbol_at(digs[k]);
        c.last   = (k == digs.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [SYM_W-1:0] sym, logic lst);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        $error("character 0x%02h arrived with no value pending", sym);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      if (want.symbol !== sym) begin
        $error("symbol: expected 0x%02h, got 0x%02h", want.symbol, sym);
        mismatches++;
      end
      if (want.last !== lst) begin
        $error("last: expected %b, got %b", want.last, lst);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         cfg_write;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [VALUE_BITS-1:0] value;
  logic                         out_valid;
  logic                         out_stall;
  logic [SYM_W-1:0]             symbol;
  logic                         last;

  radix_text_scoreboard sb;
  bit                   hold_armed;
  bit                   hold_served;
  int                   idle_cycles;

  signed_integer_to_radix_text #(
    .MAX_RADIX (MAX_RADIX),
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .symbol   (symbol),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_value(value);
    if (!rst && out_valid && !out_stall) sb.check_char(symbol, last);
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: free stretches and stalls of random length, one long hold-off on request.
  initial begin
    int run;
    int pick;
    out_stall <= 1'b0;
    forever begin
      out_stall <= 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 60)      run = $urandom_range(1, 5);
      else if (pick < 90) run = $urandom_range(6, 30);
      else                run = $urandom_range(100, 300);
      repeat (run) @(posedge clk);
      if (hold_armed && !hold_served) begin
        hold_served = 1'b1;
        run = HOLD_CYCLES;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      run = $urandom_range(1, 2);
        else if (pick < 95) run = $urandom_range(3, 10);
        else                run = $urandom_range(30, 120);
      end
      out_stall <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  task automatic send_value(input logic signed [VALUE_BITS-1:0] v, input bit steady);
    int gap;
    int pick;
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    gap = 0;
    if (!steady) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      gap = 0;
      else if (pick < 88) gap = $urandom_range(1, 3);
      else if (pick < 98) gap = $urandom_range(4, 20);
      else                gap = $urandom_range(40, 150);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every expected character, then let a rejected value finish its check.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_table(input logic [CFG_DATA_W-1:0] rd,
                               input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] hi);
    cfg_index <= REG_RADIX;
    cfg_data  <= rd;
    cfg_write <= 1'b1;
    @(posedge clk);
    sb.set_reg(REG_RADIX, rd);
    cfg_index <= REG_SYM_LOW;
    cfg_data  <= lo;
    cfg_write <= 1'b1;
    @(posedge clk);
    sb.set_reg(REG_SYM_LOW, lo);
    cfg_index <= REG_SYM_HIGH;
    cfg_data  <= hi;
    cfg_write <= 1'b1;
    @(posedge clk);
    sb.set_reg(REG_SYM_HIGH, hi);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [SYM_W-1:0]             tab[16];
    logic [CFG_DATA_W-1:0]        lo;
    logic [CFG_DATA_W-1:0]        hi;
    logic [CFG_DATA_W-1:0]        rd;
    logic signed [VALUE_BITS-1:0] v;
    int unsigned                  r;
    int                           j;
    int                           n;
    int                           useful;
    bit                           fresh;
    bit                           steady;
    bit                           first;

    sb          = new();
    hold_armed  = 1'b0;
    hold_served = 1'b0;
    idle_cycles = 0;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_RADIX;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    value     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset: digits 8 and 9 both read '1', so nothing comes out.
    send_value(32'sd0, 0);
    send_value(32'sd7, 0);
    send_value(-32'sd7, 0);
    send_value(32'sh7fff_ffff, 0);
    send_value(32'sh8000_0000, 0);
    send_value(32'sd1000000000, 0);
    send_value(-32'sd99, 0);
    settle();

    // Hex with a zero byte as the symbol for digit 0.
    program_table(64'd16, {HEX_LOW[63:8], 8'h00}, HEX_HIGH);
    send_value(32'sd0, 0);
    send_value(32'sh8000_0000, 0);
    send_value(32'sd255, 0);
    send_value(-32'sd1, 0);
    settle();

    // Binary; signs and repeats beyond the radix are ignored.
    program_table(64'd2, 64'h2B2B_2B2B_2B2B_3130, 64'h2D2D_2D2D_2D2D_2D2D);
    send_value(32'sh8000_0000, 0);
    send_value(32'sh7fff_ffff, 0);
    send_value(32'sd5, 0);
    settle();

    // Unusable tables: nothing comes out.
    program_table(64'd1, HEX_LOW, HEX_HIGH);
    send_value(32'sd12345, 0);
    settle();
    program_table(64'd0, HEX_LOW, HEX_HIGH);
    send_value(-32'sd5, 0);
    settle();
    program_table(64'd17, HEX_LOW, HEX_HIGH);
    send_value(32'sd77, 0);
    settle();
    program_table(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(32'sd3, 0);
    settle();
    program_table(64'd16, 64'h3736_3534_2B32_3130, HEX_HIGH);
    send_value(32'sd100, 0);
    settle();
    program_table(64'd16, HEX_LOW, 64'h2D45_4443_4241_3938);
    send_value(-32'sd100, 0);
    settle();
    program_table(64'd16, HEX_LOW, 64'h4645_4443_4241_3038);
    send_value(32'sd9, 0);
    settle();

    // Random tables and values; a few broken tables in between.
    useful = 0;
    first  = 1'b1;
    while (useful < RANDOM_ITEMS) begin
      r = $urandom_range(2, 16);
      for (int i = 0; i < 16; i++) begin
        do begin
          tab[i] = SYM_W'($urandom_range(0, 255));
          fresh  = (tab[i] != SYM_PLUS) && (tab[i] != SYM_MINUS);
          for (int k = 0; k < i; k++)
            if (tab[k] == tab[i]) fresh = 1'b0;
        end while (!fresh);
      end
      // junk in an unused entry must not matter
      if (r < 16 && $urandom_range(0, 1))
        tab[$urandom_range(r, 15)] = $urandom_range(0, 1) ? SYM_MINUS : tab[0];
      if (!first && $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: r = $urandom_range(0, 1);
          1: r = $urandom_range(17, 31);
          2: tab[$urandom_range(0, r - 1)] = $urandom_range(0, 1) ? SYM_PLUS : SYM_MINUS;
          default: begin
            j      = $urandom_range(1, r - 1);
            tab[j] = tab[$urandom_range(0, j - 1)];
          end
        endcase
      end
      for (int i = 0; i < 8; i++) begin
        lo[i*SYM_W +: SYM_W] = tab[i];
        hi[i*SYM_W +: SYM_W] = tab[i+8];
      end
      rd = {$urandom, $urandom};
      rd[RADIX_W-1:0] = RADIX_W'(r);
      program_table(rd, lo, hi);

      steady = first || ($urandom_range(0, 3) == 0);
      if (first) hold_armed = 1'b1;
      n = sb.table_ok() ? $urandom_range(20, 50) : $urandom_range(3, 6);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0, 1, 2: v = $urandom;
          3:       v = $urandom >> $urandom_range(1, 31);
          4:       v = -($urandom >> $urandom_range(1, 31));
          5:       v = $urandom_range(0, 40) - 20;
          6:       v = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
          default: v = $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
        endcase
        send_value(v, steady);
      end
      if (sb.table_ok()) useful += n;
      settle();
      first = 1'b0;
    end

    if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
